// File: rtl/assert_macros.svh
// Assertion macros shared by the RHSV RTL files.
// Expects clk and rst_n (synchronous, active low) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhsv assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhsv assertion failed");

`endif

// File: rtl/rhsv_pkg.sv
// Package for the RGB to HSV pixel converter: payload structs and fixed constants.
// No dependencies; used by every RHSV module.
`default_nettype none

package rhsv_pkg;

  // Field widths
  localparam int CH_W   = 8;   // color channel
  localparam int NUM_W  = 11;  // hue numerator, below 6*delta <= 1530
  localparam int N_W    = 24;  // dividend of the reciprocal dividers
  localparam int Q_W    = 16;  // quotient (hue, saturation)

  // Reciprocal divider: recip(d) = floor(2^RECIP_SH / d)
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = 25;
  localparam int RecipOne = 1 << RECIP_SH;

  // floor(32768*num/3) = 10922*num + floor(2*num/3)
  localparam logic [13:0] HUE_K    = 14'd10922;
  // floor(y/3) = (y*5462) >> 14, exact for y < 8192
  localparam logic [12:0] THIRD_M  = 13'd5462;
  localparam int          THIRD_SH = 14;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_t;

  typedef struct packed {
    logic [Q_W-1:0]  hue;
    logic [Q_W-1:0]  saturation;
    logic [CH_W-1:0] brightness;
  } out_t;

  // Classified pixel as it sits in the queue
  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  delta;
    logic [NUM_W-1:0] num;
  } item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/rhsv_front.sv
// Front end: accepts a pixel, finds max, delta and the hue sector numerator.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_front
  import rhsv_pkg::*;
(
  input  wire logic    start,
  output logic         busy,
  input  wire in_t     in_data,
  input  wire q_stat_t stat,
  output logic         push,
  output item_t        push_item
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  sector_t          sector;
  logic [CH_W-1:0]  r, g, b;
  logic [CH_W-1:0]  mx, mn, delta;
  logic [NUM_W-1:0] d_ext, two_d, four_d, six_d;
  logic [NUM_W-1:0] num;

  assign r = in_data.red;
  assign g = in_data.green;
  assign b = in_data.blue;

  // Transfer when the queue has room
  assign busy = stat.full;
  assign push = start && !busy;

  // Largest channel, red wins ties, then green
  always_comb begin
    if (r >= g && r >= b) begin
      sector = SEC_RED;
      mx     = r;
    end else if (g >= b) begin
      sector = SEC_GREEN;
      mx     = g;
    end else begin
      sector = SEC_BLUE;
      mx     = b;
    end
  end

  // Smallest channel and spread
  always_comb begin
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end
  assign delta = mx - mn;

  assign d_ext  = NUM_W'(delta);
  assign two_d  = d_ext << 1;
  assign four_d = d_ext << 2;
  assign six_d  = two_d + four_d;

  // Hue numerator over 6*delta; modular math, the result is in [0, 6*delta) for a nonzero delta and zero otherwise
  always_comb begin
    case (sector)
      SEC_RED: begin
        num = NUM_W'(g) - NUM_W'(b) + ((g < b) ? six_d : '0);
      end
      SEC_GREEN: begin
        num = two_d + NUM_W'(b) - NUM_W'(r);
      end
      SEC_BLUE: begin
        num = four_d + NUM_W'(r) - NUM_W'(g);
      end
      default: begin
        num = '0;
      end
    endcase
  end

  assign push_item.mx    = mx;
  assign push_item.delta = delta;
  assign push_item.num   = num;

endmodule

`default_nettype wire

// File: rtl/rhsv_queue.sv
// Short FIFO between the front end and the back end.
// Depends on rhsv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhsv_queue
  import rhsv_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_stat_t    stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign pop_item   = entry_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_IMP(a_q_no_overflow, push, !stat.full)
  `ASSERT_IMP(a_q_no_underflow, pop, !stat.empty)
  `ASSERT_NXT(a_q_count_up, push && !pop, count_r == ($past(count_r) + CNT_W'(1)))

endmodule

`default_nettype wire

// File: rtl/rhsv_div.sv
// Two-stage reciprocal divider: q = floor(n / d) for 24-bit n, 8-bit d, q below 2^16.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_div
  import rhsv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic [N_W-1:0]   n,
  input  wire logic [CH_W-1:0]  d,
  output logic                  out_vld,
  output logic [Q_W-1:0]        q
);

  localparam int DIV_N = 2 ** CH_W;

  logic [RECIP_W-1:0]       recip_tbl [DIV_N];
  logic [N_W+RECIP_W-1:0]   prod;
  logic                     s1_vld_r;
  logic [Q_W-1:0]           s1_q0_r;
  logic [N_W-1:0]           s1_n_r;
  logic [CH_W-1:0]          s1_d_r;
  logic [N_W-1:0]           rem;
  logic [Q_W-1:0]           q_nxt;
  logic [Q_W-1:0]           q_r;
  logic                     vld_r;

  // Reciprocal constants, worked out at elaboration; entry zero is read only for a zero divisor
  assign recip_tbl[0] = '0;
  for (genvar gi = 1; gi < DIV_N; gi++) begin : g_recip
    localparam logic [RECIP_W-1:0] RecipVal = RECIP_W'(RecipOne / gi);
    assign recip_tbl[gi] = RecipVal;
  end

  // Stage 1: estimate, low by at most one
  assign prod = (N_W+RECIP_W)'(n) * (N_W+RECIP_W)'(recip_tbl[d]);

  // Stage 2: remainder check bumps the estimate
  assign rem   = s1_n_r - N_W'(s1_q0_r) * N_W'(s1_d_r);
  assign q_nxt = s1_q0_r + ((rem >= N_W'(s1_d_r)) ? Q_W'(1) : Q_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      vld_r    <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_q0_r <= prod[RECIP_SH +: Q_W];
    s1_n_r  <= n;
    s1_d_r  <= d;
    q_r     <= q_nxt;
  end

  assign out_vld = vld_r;
  assign q       = q_r;

endmodule

`default_nettype wire

// File: rtl/rhsv_back.sv
// Back end: pops classified pixels, scales the dividends, runs both dividers
// and registers the result. Depends on rhsv_pkg, rhsv_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhsv_back
  import rhsv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_stat_t stat,
  input  wire item_t   pop_item,
  output logic         pop,
  output logic         out_strobe,
  output out_t         out_data
);

  logic [N_W-1:0]   hue_base;
  logic [NUM_W:0]   twice;
  logic [24:0]      third_prod;
  logic [N_W-1:0]   hue_n;
  logic [N_W-1:0]   sat_n;

  logic             p0_vld_r;
  logic [N_W-1:0]   p0_hue_n_r;
  logic [N_W-1:0]   p0_sat_n_r;
  logic [CH_W-1:0]  p0_mx_r;
  logic [CH_W-1:0]  p0_delta_r;
  logic             p0_zero_r;

  logic [CH_W-1:0]  s1_mx_r, s2_mx_r;
  logic             s1_zero_r, s2_zero_r;

  logic             hue_vld, sat_vld;
  logic [Q_W-1:0]   hue_q, sat_q;

  logic             strobe_r;
  out_t             data_r;

  // Back end never stalls, so drain the queue every cycle that it holds an entry
  assign pop = !stat.empty;

  // Hue dividend floor(32768*num/3), split to avoid a divide by three
  assign hue_base   = N_W'(HUE_K) * N_W'(pop_item.num);
  assign twice      = {pop_item.num, 1'b0};
  assign third_prod = 25'(twice) * 25'(THIRD_M);
  assign hue_n      = hue_base + N_W'(third_prod[THIRD_SH +: NUM_W]);

  // Saturation dividend 65535*delta
  assign sat_n = {pop_item.delta, {Q_W{1'b0}}} - N_W'(pop_item.delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      p0_vld_r <= pop;
      strobe_r <= hue_vld && sat_vld;
    end
  end

  // Payload pipeline, kept in step with the dividers
  always_ff @(posedge clk) begin
    p0_hue_n_r <= hue_n;
    p0_sat_n_r <= sat_n;
    p0_mx_r    <= pop_item.mx;
    p0_delta_r <= pop_item.delta;
    p0_zero_r  <= (pop_item.delta == '0);
    s1_mx_r    <= p0_mx_r;
    s1_zero_r  <= p0_zero_r;
    s2_mx_r    <= s1_mx_r;
    s2_zero_r  <= s1_zero_r;
    data_r.brightness <= s2_mx_r;
    data_r.hue        <= s2_zero_r ? '0 : hue_q;
    data_r.saturation <= s2_zero_r ? '0 : sat_q;
  end

  // hue = floor(32768*num / (3*delta))
  rhsv_div u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p0_vld_r),
    .n       (p0_hue_n_r),
    .d       (p0_delta_r),
    .out_vld (hue_vld),
    .q       (hue_q)
  );

  // saturation = floor(65535*delta / max)
  rhsv_div u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p0_vld_r),
    .n       (p0_sat_n_r),
    .d       (p0_mx_r),
    .out_vld (sat_vld),
    .q       (sat_q)
  );

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

  `ASSERT_IMP(a_bk_latency, out_strobe, $past(pop, 4))
  `ASSERT_IMP(a_bk_grey_hue, out_strobe && (out_data.saturation == '0), out_data.hue == '0)
  `ASSERT_IMP(a_bk_black_sat, out_strobe && (out_data.brightness == '0),
              out_data.saturation == '0)

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, top level: front end, queue and back end.
// Depends on rhsv_pkg, rhsv_front, rhsv_queue and rhsv_back.
//
// One pixel per clock while busy is low. A pixel transfers on a rising edge with
// start high and busy low. Its hue, saturation and brightness go out in order on
// out_data, with out_strobe high for one cycle, after passing the queue slot, the
// dividend scaling register, the two stages of each reciprocal-multiply divider
// and the output register. The back end drains the queue whenever it holds a
// pixel and the receiver cannot stall, so with two or more queue slots the queue
// never fills and busy stays low.
`default_nettype none

module rgb_to_hsv_pixel
  import rhsv_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  q_stat_t stat;
  logic    push, pop;
  item_t   push_item, pop_item;

  rhsv_front u_front (
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  rhsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  rhsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: verif/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 100ps
// Checker for the RGB to HSV pixel converter: predicts hue, saturation and
// brightness for every pixel transfer and compares them with the result strobes.
// Depends on rhsv_pkg for the in_t and out_t payload structs.

module rgb_to_hsv_pixel_checker
  import rhsv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_strobe,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  // Which channel is taken as the largest; ties go red, then green
  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_chan_t;

  out_t expected_hsv[$];

  // Exact integer conversion of one pixel
  function automatic out_t hsv_of(input in_t px);
    int r, g, b, mx, mn, delta, num;
    max_chan_t leader;
    out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    if (r >= g && r >= b) begin
      mx = r;
      leader = MAX_RED;
    end else if (g >= b) begin
      mx = g;
      leader = MAX_GREEN;
    end else begin
      mx = b;
      leader = MAX_BLUE;
    end
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;

    res = '0;
    res.brightness = CH_W'(mx);
    // grey pixels, black among them, keep hue and saturation at zero
    if (delta != 0) begin
      res.saturation = Q_W'((65535 * delta) / mx);
      case (leader)
        MAX_RED: begin
          num = g - b;
          if (num < 0) num += 6 * delta;   // wraps below zero degrees
        end
        MAX_GREEN: num = 2 * delta + (b - r);
        default:   num = 4 * delta + (r - g);
      endcase
      res.hue = Q_W'((num * 65536) / (6 * delta));
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Score result transfers against the oldest prediction, then log new pixels
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (expected_hsv.size() == 0) begin
        $error("result with no pixel pending: hue %0d saturation %0d brightness %0d",
               out_data.hue, out_data.saturation, out_data.brightness);
        fail_count++;
      end else begin
        want = expected_hsv.pop_front();
        compare_field("hue", want.hue, out_data.hue);
        compare_field("saturation", want.saturation, out_data.saturation);
        compare_field("brightness", want.brightness, out_data.brightness);
      end
    end
    if (rst_n && start && !busy) expected_hsv.push_back(hsv_of(in_data));
    pending = expected_hsv.size();
  end

endmodule

// File: verif/rgb_to_hsv_pixel_test.sv
`timescale 1ns / 100ps
// Testbench top for rgb_to_hsv_pixel: clock, reset, directed and random pixels.
// Depends on rhsv_pkg, the rgb_to_hsv_pixel RTL and rgb_to_hsv_pixel_checker.

module rgb_to_hsv_pixel_test;
  import rhsv_pkg::*;

  localparam int ClkPeriod    = 8;
  localparam int ResetCycles  = 6;
  localparam int RandomPixels = 750;
  localparam int CalmTail     = 150;     // last pixels go back to back
  localparam int DrainCycles  = 12;      // wait after the last pending result is scored
  localparam int CycleLimit   = 100000;

  // Flavors of random pixel
  typedef enum logic [1:0] {MIX_UNIFORM, MIX_NEAR_GREY, MIX_TIE, MIX_EXTREME} pixel_mix_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_strobe;
  in_t  in_data;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycle_count;

  rgb_to_hsv_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  rgb_to_hsv_pixel_checker hsv_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_t rgb(input int r, input int g, input int b);
    in_t px;
    px.red = CH_W'(r);
    px.green = CH_W'(g);
    px.blue = CH_W'(b);
    return px;
  endfunction

  // 0, 255 or anything, for saturated and black-channel colors
  function automatic logic [CH_W-1:0] extreme_byte();
    case ($urandom_range(2, 0))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic in_t random_pixel();
    pixel_mix_t mix;
    int base, odd;
    in_t px;
    mix = pixel_mix_t'($urandom_range(3, 0));
    px = in_t'(24'($urandom));
    case (mix)
      MIX_NEAR_GREY: begin
        // delta of 0..4 stresses the smallest divisors
        base = $urandom_range(251, 0);
        px = rgb(base + $urandom_range(4, 0), base + $urandom_range(4, 0),
                 base + $urandom_range(4, 0));
      end
      MIX_TIE: begin
        // two or three channels equal: ties at the top or at the bottom
        base = $urandom_range(255, 0);
        odd = $urandom_range(255, 0);
        px = rgb(base, base, base);
        case ($urandom_range(3, 0))
          0: px.red = CH_W'(odd);
          1: px.green = CH_W'(odd);
          2: px.blue = CH_W'(odd);
          default: ;
        endcase
      end
      MIX_EXTREME: begin
        px.red = extreme_byte();
        px.green = extreme_byte();
        px.blue = extreme_byte();
      end
      default: ;
    endcase
    return px;
  endfunction

  // One pixel transfer, optionally after an idle burst; returns at a falling edge
  task automatic send_pixel(input in_t px, input bit may_idle);
    if (may_idle && $urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      in_data <= in_t'(24'($urandom));   // junk while idle must be ignored
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    in_t directed[$];

    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Black, white, primaries, secondaries, ties, hue wrap, unit deltas
    directed = '{rgb(0, 0, 0), rgb(255, 255, 255), rgb(128, 128, 128),
                 rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
                 rgb(255, 255, 0), rgb(0, 255, 255), rgb(255, 0, 255),
                 rgb(255, 255, 1), rgb(1, 255, 255), rgb(200, 7, 200),
                 rgb(200, 10, 90), rgb(200, 90, 10), rgb(10, 200, 90),
                 rgb(90, 200, 10), rgb(10, 90, 200), rgb(90, 10, 200),
                 rgb(1, 0, 0), rgb(0, 1, 0), rgb(0, 0, 1), rgb(255, 254, 254),
                 rgb(170, 85, 85), rgb(85, 170, 85), rgb(85, 85, 170)};
    foreach (directed[i]) send_pixel(directed[i], 1'b1);

    for (int i = 0; i < RandomPixels; i++)
      send_pixel(random_pixel(), i < RandomPixels - CalmTail);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
